### hdl/bsos_pkg.sv
// ----------------------------------------------------------------------------
// bsos_pkg
// Shared types and constants of the beacon-seek obstacle sequencer.
// ----------------------------------------------------------------------------
package bsos_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_TICKS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_TICKS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_TICKS       = 3'd5;

    // Register reset values
    localparam logic [9:0] RST_OBSTACLE_THRESHOLD = 10'd300;
    localparam logic [9:0] RST_TURN_TICKS         = 10'd156;
    localparam logic [9:0] RST_SEARCH_LIMIT_TICKS = 10'd936;
    localparam logic [7:0] RST_REVERSE_TICKS      = 8'd100;
    localparam logic [7:0] RST_ADVANCE_TICKS      = 8'd120;
    localparam logic [7:0] RST_CRUISE_TICKS       = 8'd5;

    // Fixed durations in 10 ms ticks
    localparam logic [7:0] LONG_HALF   = 8'd50;
    localparam logic [7:0] SHORT_HALF  = 8'd16;
    localparam logic [7:0] PAUSE_TICKS = 8'd10;
    localparam logic [2:0] FLASH_STEPS = 3'd6;

    // Bridge pin patterns: right pair in [3:2], left pair in [1:0]
    localparam logic [3:0] DRV_COAST = 4'd0;
    localparam logic [3:0] DRV_FWD   = 4'd5;
    localparam logic [3:0] DRV_REV   = 4'd10;
    localparam logic [3:0] DRV_BRAKE = 4'd15;
    localparam logic [3:0] DRV_RTURN = 4'd13;
    localparam logic [3:0] DRV_LTURN = 4'd7;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_SEARCH  = 4'd1,
        PH_FAIL    = 4'd2,
        PH_CHECK   = 4'd3,
        PH_CRUISE  = 4'd4,
        PH_AVOID   = 4'd5,
        PH_PAUSE   = 4'd6,
        PH_REVERSE = 4'd7,
        PH_TLEFT   = 4'd8,
        PH_ADVANCE = 4'd9,
        PH_TRIGHT  = 4'd10,
        PH_FINAL   = 4'd11,
        PH_HALT    = 4'd12
    } t_phase;

    typedef struct packed {
        logic [9:0] obstacle_threshold;
        logic [9:0] turn_ticks;
        logic [9:0] search_limit_ticks;
        logic [7:0] reverse_ticks;
        logic [7:0] advance_ticks;
        logic [7:0] cruise_ticks;
    } t_cfg;

    typedef struct packed {
        logic       beacon_left;
        logic       beacon_right;
        logic       encoder_left;
        logic       encoder_right;
        logic [9:0] prox_left;
        logic [9:0] prox_right;
        logic       tick;
    } t_sample;

    typedef struct packed {
        logic [1:0] right_drive;
        logic [1:0] left_drive;
        logic       leds_on;
        logic [3:0] phase_now;
        logic       halted;
    } t_result;

endpackage

### hdl/beacon_seek_obstacle_sequencer.sv
// ----------------------------------------------------------------------------
// beacon_seek_obstacle_sequencer
// Drive sequencer for a two-wheel robot that seeks a beacon and avoids
// obstacles, one sensor sample per request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one sensor sample per request (beacon and encoder levels,
//   two proximity readings, 10 ms tick flag). Master stream: one result per
//   sample (bridge pins, LED level, phase, halted flag).
//   Output: a result is registered in the output register or, on a stall,
//   in the skid entry. Throughput: one sample per clock while o_s_tready
//   is high; the phase update is one registered step of the phase machine.
//   Stall: while the receiver holds i_m_tready low, one more sample is taken
//   into a skid entry, then o_s_tready drops until the output drains.
//   Reset: phase goes to the start flash, timers and counters clear, motors
//   coast, LEDs off, configuration registers take their default values.
//   Configuration: write i_cfg_wdata to register i_cfg_index while
//   i_cfg_we is high, only while no sample is in flight.
// ----------------------------------------------------------------------------
module beacon_seek_obstacle_sequencer import bsos_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [0] beacon_left, [1] beacon_right, [2] encoder_left, [3] encoder_right,
    // [13:4] prox_left, [23:14] prox_right, [24] tick, [31:25] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [1:0] right_drive, [3:2] left_drive, [4] leds_on, [8:5] phase_now,
    // [9] halted, [15:10] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg    w_cfg;
    t_sample w_sample;
    t_result w_result;
    t_result w_out;
    logic    w_push;
    logic    w_ready;

    assign w_sample.beacon_left   = i_s_tdata[0];
    assign w_sample.beacon_right  = i_s_tdata[1];
    assign w_sample.encoder_left  = i_s_tdata[2];
    assign w_sample.encoder_right = i_s_tdata[3];
    assign w_sample.prox_left     = i_s_tdata[13:4];
    assign w_sample.prox_right    = i_s_tdata[23:14];
    assign w_sample.tick          = i_s_tdata[24];

    assign w_push     = i_s_tvalid && w_ready;
    assign o_s_tready = w_ready;

    bsos_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    bsos_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_push),
        .i_sample (w_sample),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    bsos_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_ready  (w_ready),
        .o_valid  (o_m_tvalid),
        .o_result (w_out),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = {6'd0, w_out.halted, w_out.phase_now, w_out.leds_on,
                        w_out.left_drive, w_out.right_drive};

endmodule

### hdl/bsos_cfg.sv
// ----------------------------------------------------------------------------
// bsos_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bsos_cfg import bsos_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_threshold <= RST_OBSTACLE_THRESHOLD;
            r_cfg.turn_ticks         <= RST_TURN_TICKS;
            r_cfg.search_limit_ticks <= RST_SEARCH_LIMIT_TICKS;
            r_cfg.reverse_ticks      <= RST_REVERSE_TICKS;
            r_cfg.advance_ticks      <= RST_ADVANCE_TICKS;
            r_cfg.cruise_ticks       <= RST_CRUISE_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OBSTACLE_THRESHOLD: r_cfg.obstacle_threshold <= i_cfg_wdata;
                CFG_TURN_TICKS:         r_cfg.turn_ticks         <= i_cfg_wdata;
                CFG_SEARCH_LIMIT_TICKS: r_cfg.search_limit_ticks <= i_cfg_wdata;
                CFG_REVERSE_TICKS:      r_cfg.reverse_ticks      <= i_cfg_wdata[7:0];
                CFG_ADVANCE_TICKS:      r_cfg.advance_ticks      <= i_cfg_wdata[7:0];
                CFG_CRUISE_TICKS:       r_cfg.cruise_ticks       <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/bsos_core.sv
// ----------------------------------------------------------------------------
// bsos_core
// Phase machine: advances timers, edge counter and flash pattern by one
// sample on every accepted request and forms the result of that sample.
// ----------------------------------------------------------------------------
module bsos_core import bsos_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase     r_phase,       n_phase;
    logic [7:0] r_tick_timer,  n_tick_timer;
    logic [9:0] r_edge_cnt,    n_edge_cnt;
    logic       r_prev_enc_l,  n_prev_enc_l;
    logic       r_prev_enc_r,  n_prev_enc_r;
    logic [2:0] r_flash_step,  n_flash_step;
    logic [3:0] r_drive,       n_drive;
    logic       r_led,         n_led;

    logic [7:0] w_dur;
    logic [8:0] w_t;
    logic       w_tdone;
    logic [2:0] w_fs_inc;
    logic       w_fdone;
    logic [2:0] w_fs_next;
    logic       w_led_next;
    logic [9:0] w_ec_inc;
    logic       w_obstacle;

    // Duration of the current timed phase
    always_comb begin
        case (r_phase) inside
            PH_START, PH_FAIL, PH_FINAL: w_dur = LONG_HALF;
            PH_AVOID:                    w_dur = SHORT_HALF;
            PH_PAUSE:                    w_dur = PAUSE_TICKS;
            PH_CRUISE:                   w_dur = i_cfg.cruise_ticks;
            PH_REVERSE:                  w_dur = i_cfg.reverse_ticks;
            PH_ADVANCE:                  w_dur = i_cfg.advance_ticks;
            default:                     w_dur = 8'd0;
        endcase
    end

    assign w_t      = {1'b0, r_tick_timer} + {8'd0, i_sample.tick};
    assign w_tdone  = (w_t >= {1'b0, w_dur});
    assign w_fs_inc = r_flash_step + 3'd1;
    assign w_fdone  = w_tdone && (w_fs_inc >= FLASH_STEPS);
    assign w_fs_next  = w_tdone ? w_fs_inc : r_flash_step;
    assign w_led_next = ~w_fs_next[0];
    assign w_ec_inc   = r_edge_cnt + 10'd1;
    assign w_obstacle = (i_sample.prox_left  >= i_cfg.obstacle_threshold) ||
                        (i_sample.prox_right >= i_cfg.obstacle_threshold);

    always_comb begin
        n_phase      = r_phase;
        n_tick_timer = w_tdone ? 8'd0 : w_t[7:0];
        n_edge_cnt   = r_edge_cnt;
        n_prev_enc_l = r_prev_enc_l;
        n_prev_enc_r = r_prev_enc_r;
        n_flash_step = r_flash_step;
        n_drive      = r_drive;
        n_led        = r_led;

        unique case (r_phase) inside
            PH_START, PH_FAIL, PH_AVOID, PH_FINAL: begin
                if (w_fdone) begin
                    n_tick_timer = 8'd0;
                    n_flash_step = 3'd0;
                    n_led        = 1'b0;
                    case (r_phase)
                        PH_START: begin
                            n_phase      = PH_SEARCH;
                            n_edge_cnt   = 10'd0;
                            n_prev_enc_l = i_sample.encoder_left;
                        end
                        PH_FAIL: begin
                            n_drive = DRV_BRAKE;
                            n_phase = PH_HALT;
                        end
                        PH_AVOID: n_phase = PH_PAUSE;
                        default:  n_phase = PH_HALT;
                    endcase
                end else begin
                    n_flash_step = w_fs_next;
                    n_led        = w_led_next;
                end
            end
            PH_SEARCH: begin
                n_tick_timer = r_tick_timer;
                if (i_sample.beacon_left || i_sample.beacon_right) begin
                    n_drive      = i_sample.beacon_left ? DRV_RTURN : DRV_LTURN;
                    n_prev_enc_l = i_sample.encoder_left;
                    if (i_sample.encoder_left != r_prev_enc_l) begin
                        if (r_edge_cnt >= i_cfg.search_limit_ticks) begin
                            n_phase      = PH_FAIL;
                            n_tick_timer = 8'd0;
                            n_flash_step = 3'd0;
                            n_led        = 1'b0;
                        end else begin
                            n_edge_cnt = w_ec_inc;
                        end
                    end
                end else begin
                    n_phase      = PH_CHECK;
                    n_tick_timer = 8'd0;
                    n_flash_step = 3'd0;
                    n_led        = 1'b0;
                end
            end
            PH_CHECK: begin
                n_tick_timer = 8'd0;
                n_flash_step = 3'd0;
                n_led        = 1'b0;
                if (w_obstacle) begin
                    n_drive = DRV_BRAKE;
                    n_phase = (i_sample.beacon_left && i_sample.beacon_right) ?
                              PH_FINAL : PH_AVOID;
                end else begin
                    n_drive = DRV_FWD;
                    n_phase = PH_CRUISE;
                end
            end
            PH_CRUISE, PH_PAUSE, PH_REVERSE, PH_ADVANCE: begin
                if (w_tdone) begin
                    n_flash_step = 3'd0;
                    n_led        = 1'b0;
                    case (r_phase)
                        PH_CRUISE: begin
                            n_phase      = PH_SEARCH;
                            n_edge_cnt   = 10'd0;
                            n_prev_enc_l = i_sample.encoder_left;
                        end
                        PH_PAUSE: begin
                            n_drive = DRV_REV;
                            n_phase = PH_REVERSE;
                        end
                        PH_REVERSE: begin
                            n_drive      = DRV_LTURN;
                            n_phase      = PH_TLEFT;
                            n_edge_cnt   = 10'd0;
                            n_prev_enc_r = i_sample.encoder_right;
                        end
                        default: begin
                            n_drive      = DRV_RTURN;
                            n_phase      = PH_TRIGHT;
                            n_edge_cnt   = 10'd0;
                            n_prev_enc_l = i_sample.encoder_left;
                        end
                    endcase
                end
            end
            PH_TLEFT, PH_TRIGHT: begin
                logic enc_now;
                logic enc_prev;
                logic [9:0] ec;
                enc_now  = (r_phase == PH_TLEFT) ? i_sample.encoder_right
                                                 : i_sample.encoder_left;
                enc_prev = (r_phase == PH_TLEFT) ? r_prev_enc_r : r_prev_enc_l;
                n_tick_timer = r_tick_timer;
                ec = r_edge_cnt;
                if ((r_edge_cnt < i_cfg.turn_ticks) && (enc_now != enc_prev)) begin
                    ec = w_ec_inc;
                end
                n_edge_cnt = ec;
                if (r_phase == PH_TLEFT) begin
                    n_prev_enc_r = enc_now;
                end else begin
                    n_prev_enc_l = enc_now;
                end
                if (ec >= i_cfg.turn_ticks) begin
                    n_tick_timer = 8'd0;
                    n_flash_step = 3'd0;
                    n_led        = 1'b0;
                    if (r_phase == PH_TLEFT) begin
                        n_drive = DRV_FWD;
                        n_phase = PH_ADVANCE;
                    end else begin
                        n_drive      = DRV_BRAKE;
                        n_phase      = PH_SEARCH;
                        n_edge_cnt   = 10'd0;
                        n_prev_enc_l = i_sample.encoder_left;
                    end
                end
            end
            default: begin
                // halt and any unused code: brake and stay
                n_drive      = DRV_BRAKE;
                n_phase      = PH_HALT;
                n_tick_timer = 8'd0;
                n_flash_step = 3'd0;
                n_led        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_tick_timer <= 8'd0;
            r_edge_cnt   <= 10'd0;
            r_prev_enc_l <= 1'b0;
            r_prev_enc_r <= 1'b0;
            r_flash_step <= 3'd0;
            r_drive      <= DRV_COAST;
            r_led        <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick_timer <= n_tick_timer;
            r_edge_cnt   <= n_edge_cnt;
            r_prev_enc_l <= n_prev_enc_l;
            r_prev_enc_r <= n_prev_enc_r;
            r_flash_step <= n_flash_step;
            r_drive      <= n_drive;
            r_led        <= n_led;
        end
    end

    // Result of the current request, taken from the next state
    assign o_result.right_drive = n_drive[3:2];
    assign o_result.left_drive  = n_drive[1:0];
    assign o_result.leds_on     = n_led;
    assign o_result.phase_now   = n_phase;
    assign o_result.halted      = (n_phase == PH_HALT);

`ifndef SYNTHESIS
    a_halt_brakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT) |-> (r_drive == DRV_BRAKE))
        else $error("halt phase without brakes");

    a_led_only_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led |-> (r_phase == PH_START || r_phase == PH_FAIL ||
                   r_phase == PH_AVOID || r_phase == PH_FINAL))
        else $error("LEDs lit outside a flash phase");

    a_flash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flash_step < FLASH_STEPS)
        else $error("flash step out of range");
`endif

endmodule

### hdl/bsos_out.sv
// ----------------------------------------------------------------------------
// bsos_out
// Result register with one skid entry, so a stalled receiver does not
// stall the sample stream until both entries are full.
// ----------------------------------------------------------------------------
module bsos_out import bsos_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    w_free;

    assign w_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (!w_free && i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry filled while output register empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule
